// ===== rtl/ssa_pkg.sv =====
// shared types, constants and command codes for the slab slot allocator
package ssa_pkg;

  // pool geometry
  localparam int MaxSlabs  = 8;
  localparam int SlabW     = 3;
  localparam int HeadW     = 4;
  localparam int SlabWords = 32;
  localparam int WordW     = 5;
  localparam int WordBits  = 64;
  localparam int MemAw     = SlabW + WordW;
  localparam int AddrW     = 17;
  localparam int ObjW      = 15;
  localparam int SizeW     = 16;
  localparam int SbW       = 15;
  localparam int CountW    = 12;
  localparam int MaxOrder  = 2;

  localparam logic [HeadW-1:0]    NoSlab  = 4'd8;
  localparam logic [WordBits-1:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  // slab classes
  localparam logic [1:0] ClsUnused  = 2'd0;
  localparam logic [1:0] ClsPartial = 2'd1;
  localparam logic [1:0] ClsFull    = 2'd2;
  localparam logic [1:0] ClsEmpty   = 2'd3;

  // result status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoSlab   = 2'd1;
  localparam logic [1:0] StNotOwned = 2'd2;
  localparam logic [1:0] StZero     = 2'd3;

  // configuration register indexes
  localparam logic CfgObjectBytes = 1'b0;
  localparam logic CfgSlabOrder   = 1'b1;

  // request kinds
  localparam logic ReqAlloc = 1'b0;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] object_address;
    logic [1:0]       status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_DISPATCH, S_GET, S_MAKE, S_SCAN_RD, S_SCAN_CHK,
    S_FULL_RD, S_FULL_CHK, S_FULL_END, S_ADDR, S_FDIV, S_FCHK, S_FWR,
    S_ERD, S_ECHK, S_FPUSH, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_ACCEPT, CMD_SC, CMD_STATUS, CMD_POP, CMD_MAKE_START,
    CMD_MAKE_WR, CMD_SCAN_START, CMD_READ, CMD_NEXT, CMD_TO_FULL, CMD_MARK,
    CMD_FULL_NEXT, CMD_ADDR, CMD_FREE_DIV, CMD_IDX, CMD_FREE_RD,
    CMD_FREE_WR, CMD_EMPTY_NEXT, CMD_PUSH_FREE
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] status;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic req_free;
    logic sc_zero;
    logic partial_empty;
    logic empty_avail;
    logic can_make;
    logic ptr_last;
    logic make_last;
    logic word_ones;
    logic full;
    logic free_bad;
    logic idx_bad;
  } stat_t;

endpackage

// ===== rtl/ssa_div.sv =====
// restoring divider, one quotient bit per cycle
module ssa_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ssa_pkg::SbW-1:0]   dividend,
  input  logic [ssa_pkg::SizeW-1:0] divisor,
  output logic                     done,
  output logic [ssa_pkg::SbW-1:0]   quotient
);

  logic [ssa_pkg::SizeW-1:0] dvs;
  logic [ssa_pkg::SizeW-1:0] rem;
  logic [3:0]                cnt;
  logic                      busy;
  logic [ssa_pkg::SizeW:0]   trial;
  logic                      qbit;

  // trial subtraction for the next bit
  always_comb begin
    trial = {rem, quotient[ssa_pkg::SbW-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'(ssa_pkg::SbW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[ssa_pkg::SbW-2:0], qbit};
      rem      <= qbit ? ssa_pkg::SizeW'(trial - {1'b0, dvs}) : trial[ssa_pkg::SizeW-1:0];
    end
  end

endmodule

// ===== rtl/ssa_dpath.sv =====
// allocator datapath: config, slab lists, bitmap memory, divider and result
module ssa_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [ssa_pkg::ObjW-1:0] cfg_data,
  input  ssa_pkg::req_t           in_data,
  input  ssa_pkg::ctrl_t          ctrl,
  output ssa_pkg::stat_t          stat,
  output ssa_pkg::rsp_t           out_data
);

  logic [ssa_pkg::ObjW-1:0]   object_bytes;
  logic [1:0]                 slab_order;
  logic                       req_type;
  logic [ssa_pkg::AddrW-1:0]  req_addr;
  logic [ssa_pkg::CountW-1:0] sc;
  logic [ssa_pkg::CountW-1:0] idx;
  logic [ssa_pkg::SlabW-1:0]  slab;
  logic [ssa_pkg::WordW-1:0]  ptr;
  logic [ssa_pkg::WordW-1:0]  word_sel;
  logic [5:0]                 bit_sel;
  logic                       full;
  logic                       empty;
  logic [ssa_pkg::HeadW-1:0]  partial_head;
  logic [ssa_pkg::HeadW-1:0]  empty_head;
  logic [ssa_pkg::HeadW-1:0]  full_head;
  logic [ssa_pkg::HeadW-1:0]  slabs_made;
  logic [ssa_pkg::HeadW-1:0]  slab_link  [ssa_pkg::MaxSlabs];
  logic [1:0]                 slab_class [ssa_pkg::MaxSlabs];
  logic [ssa_pkg::AddrW-1:0]  res_addr;
  logic [1:0]                 res_status;

  logic [ssa_pkg::WordBits-1:0] slot_bitmap [ssa_pkg::SlabWords * ssa_pkg::MaxSlabs];
  logic [ssa_pkg::WordBits-1:0] rd_data;
  logic                         mem_re;
  logic                         mem_we;
  logic [ssa_pkg::MemAw-1:0]    mem_ra;
  logic [ssa_pkg::MemAw-1:0]    mem_wa;
  logic [ssa_pkg::WordBits-1:0] mem_wd;

  logic [1:0]                 o_eff;
  logic [ssa_pkg::SizeW-1:0]  size;
  logic [ssa_pkg::SbW-1:0]    sb;
  logic [4:0]                 s_addr;
  logic [13:0]                offset;
  logic                       div_start;
  logic [ssa_pkg::SbW-1:0]    div_dividend;
  logic                       div_done;
  logic [ssa_pkg::SbW-1:0]    div_q;
  logic [12:0]                nw_sum;
  logic [5:0]                 nw_m1;
  logic [5:0]                 ptr_p1;
  logic [ssa_pkg::WordBits-1:0] tail_mask;
  logic [ssa_pkg::WordBits-1:0] sc_mask;
  logic [5:0]                 first_zero;
  logic [ssa_pkg::WordBits-1:0] mark_word;
  logic [ssa_pkg::HeadW-1:0]  own_head;
  logic [ssa_pkg::SlabW-1:0]  prev;
  logic [ssa_pkg::AddrW-1:0]  base;
  logic [26:0]                prod;
  logic [ssa_pkg::WordBits-1:0] clr_bit;

  // slab geometry from the registers
  always_comb begin
    o_eff  = (slab_order > 2'(ssa_pkg::MaxOrder)) ? 2'(ssa_pkg::MaxOrder) : slab_order;
    size   = ({1'b0, object_bytes} + 16'd7) & 16'hFFF8;
    sb     = ssa_pkg::SbW'(4096) << o_eff;
    s_addr = req_addr[16:12] >> o_eff;
    offset = req_addr[13:0] & 14'(sb - 15'd1);
    nw_sum = {1'b0, sc} + 13'd63;
    nw_m1  = nw_sum[11:6] - 6'd1;
    ptr_p1 = {1'b0, ptr} + 6'd1;
  end

  // pre-marked tail of a slab word at the current slot count
  always_comb begin
    sc_mask = (64'd1 << sc[5:0]) - 64'd1;
    if ({ptr_p1, 6'd0} <= sc) begin
      tail_mask = '0;
    end else if ({1'b0, ptr, 6'd0} >= sc) begin
      tail_mask = ssa_pkg::AllOnes;
    end else begin
      tail_mask = ~sc_mask;
    end
  end

  // first clear bit of the word read back
  always_comb begin
    first_zero = 6'd63;
    for (int i = ssa_pkg::WordBits - 1; i >= 0; i--) begin
      if (!rd_data[i]) first_zero = 6'(i);
    end
    mark_word = rd_data | (64'd1 << first_zero);
  end

  // predecessor of the slab in its list
  always_comb begin
    own_head = (slab_class[slab] == ssa_pkg::ClsFull) ? full_head : partial_head;
    prev     = '0;
    for (int p = 0; p < ssa_pkg::MaxSlabs; p++) begin
      if (slab_class[p] == slab_class[slab] && slab_link[p] == {1'b0, slab}) begin
        prev = ssa_pkg::SlabW'(p);
      end
    end
  end

  // result address of the marked slot
  always_comb begin
    base    = {14'd0, slab} << (4'd12 + {2'd0, o_eff});
    prod    = {16'd0, word_sel, bit_sel} * {11'd0, size};
    clr_bit = ~(64'd1 << idx[5:0]);
  end

  // divider operand selection
  always_comb begin
    div_start    = (ctrl.cmd == ssa_pkg::CMD_ACCEPT) || (ctrl.cmd == ssa_pkg::CMD_FREE_DIV);
    div_dividend = (ctrl.cmd == ssa_pkg::CMD_ACCEPT) ? sb : {1'b0, offset};
  end

  ssa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (size),
    .done     (div_done),
    .quotient (div_q)
  );

  // bitmap memory access
  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_ra = {slab, ptr};
    mem_wa = {slab, ptr};
    mem_wd = tail_mask;
    case (ctrl.cmd)
      ssa_pkg::CMD_READ:    mem_re = 1'b1;
      ssa_pkg::CMD_FREE_RD: begin
        mem_re = 1'b1;
        mem_ra = {slab, idx[10:6]};
      end
      ssa_pkg::CMD_MAKE_WR: mem_we = 1'b1;
      ssa_pkg::CMD_MARK: begin
        mem_we = 1'b1;
        mem_wd = mark_word;
      end
      ssa_pkg::CMD_FREE_WR: begin
        mem_we = 1'b1;
        mem_wa = {slab, idx[10:6]};
        mem_wd = rd_data & clr_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_bitmap[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= slot_bitmap[mem_ra];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_bytes <= 15'd8;
      slab_order   <= 2'd0;
    end else if (cfg_write) begin
      if (cfg_index == ssa_pkg::CfgObjectBytes) object_bytes <= cfg_data;
      else slab_order <= cfg_data[1:0];
    end
  end

  // list and class state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_head <= ssa_pkg::NoSlab;
      empty_head   <= ssa_pkg::NoSlab;
      full_head    <= ssa_pkg::NoSlab;
      slabs_made   <= '0;
      for (int i = 0; i < ssa_pkg::MaxSlabs; i++) slab_class[i] <= ssa_pkg::ClsUnused;
    end else begin
      case (ctrl.cmd)
        ssa_pkg::CMD_POP: begin
          empty_head <= slab_link[empty_head[ssa_pkg::SlabW-1:0]];
          slab_link[empty_head[ssa_pkg::SlabW-1:0]]  <= partial_head;
          slab_class[empty_head[ssa_pkg::SlabW-1:0]] <= ssa_pkg::ClsPartial;
          partial_head <= empty_head;
        end
        ssa_pkg::CMD_MAKE_START: begin
          slabs_made <= slabs_made + 4'd1;
          slab_link[slabs_made[ssa_pkg::SlabW-1:0]]  <= partial_head;
          slab_class[slabs_made[ssa_pkg::SlabW-1:0]] <= ssa_pkg::ClsPartial;
          partial_head <= slabs_made;
        end
        ssa_pkg::CMD_TO_FULL: begin
          partial_head      <= slab_link[slab];
          slab_link[slab]   <= full_head;
          slab_class[slab]  <= ssa_pkg::ClsFull;
          full_head         <= {1'b0, slab};
        end
        ssa_pkg::CMD_FREE_WR: begin
          if (own_head == {1'b0, slab}) begin
            if (slab_class[slab] == ssa_pkg::ClsFull) full_head <= slab_link[slab];
            else partial_head <= slab_link[slab];
          end else begin
            slab_link[prev] <= slab_link[slab];
          end
        end
        ssa_pkg::CMD_PUSH_FREE: begin
          if (empty) begin
            slab_link[slab]  <= empty_head;
            slab_class[slab] <= ssa_pkg::ClsEmpty;
            empty_head       <= {1'b0, slab};
          end else begin
            slab_link[slab]  <= partial_head;
            slab_class[slab] <= ssa_pkg::ClsPartial;
            partial_head     <= {1'b0, slab};
          end
        end
        default: ;
      endcase
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      ssa_pkg::CMD_ACCEPT: begin
        req_type <= in_data.req_type;
        req_addr <= in_data.free_address;
      end
      ssa_pkg::CMD_SC: sc <= (size == '0) ? '0 : div_q[ssa_pkg::CountW-1:0];
      ssa_pkg::CMD_STATUS: begin
        res_addr   <= '0;
        res_status <= ctrl.status;
      end
      ssa_pkg::CMD_POP: begin
        slab <= empty_head[ssa_pkg::SlabW-1:0];
        ptr  <= '0;
      end
      ssa_pkg::CMD_MAKE_START: begin
        slab <= slabs_made[ssa_pkg::SlabW-1:0];
        ptr  <= '0;
      end
      ssa_pkg::CMD_MAKE_WR:    ptr <= ptr + 5'd1;
      ssa_pkg::CMD_SCAN_START: begin
        slab <= partial_head[ssa_pkg::SlabW-1:0];
        ptr  <= '0;
      end
      ssa_pkg::CMD_NEXT:       ptr <= ptr + 5'd1;
      ssa_pkg::CMD_MARK: begin
        word_sel <= ptr;
        bit_sel  <= first_zero;
        full     <= &mark_word;
        ptr      <= ptr + 5'd1;
      end
      ssa_pkg::CMD_FULL_NEXT: begin
        if (rd_data != ssa_pkg::AllOnes) full <= 1'b0;
        ptr <= ptr + 5'd1;
      end
      ssa_pkg::CMD_ADDR: begin
        res_addr   <= base + prod[ssa_pkg::AddrW-1:0];
        res_status <= ssa_pkg::StOk;
      end
      ssa_pkg::CMD_FREE_DIV:   slab <= s_addr[ssa_pkg::SlabW-1:0];
      ssa_pkg::CMD_IDX:        idx <= div_q[ssa_pkg::CountW-1:0];
      ssa_pkg::CMD_FREE_WR: begin
        ptr   <= '0;
        empty <= 1'b1;
      end
      ssa_pkg::CMD_EMPTY_NEXT: begin
        if ((rd_data & ~tail_mask) != '0) empty <= 1'b0;
        ptr <= ptr + 5'd1;
      end
      ssa_pkg::CMD_PUSH_FREE: begin
        res_addr   <= '0;
        res_status <= ssa_pkg::StOk;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data.object_address <= res_addr;
      out_data.status         <= res_status;
    end
  end

  // status towards the controller
  always_comb begin
    stat.div_done      = div_done;
    stat.req_free      = (req_type != ssa_pkg::ReqAlloc);
    stat.sc_zero       = (sc == '0);
    stat.partial_empty = (partial_head >= ssa_pkg::NoSlab);
    stat.empty_avail   = (empty_head < ssa_pkg::NoSlab);
    stat.can_make      = (slabs_made < ssa_pkg::NoSlab);
    stat.ptr_last      = ({1'b0, ptr} == nw_m1);
    stat.make_last     = (ptr == 5'(ssa_pkg::SlabWords - 1));
    stat.word_ones     = (rd_data == ssa_pkg::AllOnes);
    stat.full          = full;
    stat.free_bad      = ({1'b0, s_addr} >= {2'b00, slabs_made}) ||
                         (slab_class[s_addr[ssa_pkg::SlabW-1:0]] != ssa_pkg::ClsPartial &&
                          slab_class[s_addr[ssa_pkg::SlabW-1:0]] != ssa_pkg::ClsFull);
    stat.idx_bad       = (idx >= sc);
  end

  // list heads only ever name a slab or the empty marker
  a_heads: assert property (@(posedge clk) disable iff (rst)
    partial_head <= ssa_pkg::NoSlab && empty_head <= ssa_pkg::NoSlab &&
    full_head <= ssa_pkg::NoSlab)
    else $error("list head out of range");

  // the slab count never passes the pool size
  a_made: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == ssa_pkg::CMD_MAKE_START |=> slabs_made <= ssa_pkg::NoSlab)
    else $error("too many slabs made");

  // the head of the partial list is always a partial slab
  a_part_cls: assert property (@(posedge clk) disable iff (rst)
    partial_head != ssa_pkg::NoSlab |->
      slab_class[partial_head[ssa_pkg::SlabW-1:0]] == ssa_pkg::ClsPartial)
    else $error("partial head of wrong class");

endmodule

// ===== rtl/ssa_ctrl.sv =====
// allocator controller: sequences alloc and free over the datapath
module ssa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ssa_pkg::stat_t stat,
  output ssa_pkg::ctrl_t ctrl
);

  ssa_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ssa_pkg::S_IDLE;
    else state <= state_next;
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctrl.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  assign in_stall = (state != ssa_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next    = state;
    ctrl.cmd      = ssa_pkg::CMD_NONE;
    ctrl.status   = ssa_pkg::StOk;
    ctrl.out_load = 1'b0;
    unique case (state)
      ssa_pkg::S_IDLE: begin
        if (in_valid) begin
          ctrl.cmd   = ssa_pkg::CMD_ACCEPT;
          state_next = ssa_pkg::S_DIV;
        end
      end
      ssa_pkg::S_DIV: begin
        if (stat.div_done) begin
          ctrl.cmd   = ssa_pkg::CMD_SC;
          state_next = ssa_pkg::S_DISPATCH;
        end
      end
      ssa_pkg::S_DISPATCH: begin
        if (!stat.req_free) begin
          if (stat.sc_zero) begin
            ctrl.cmd    = ssa_pkg::CMD_STATUS;
            ctrl.status = ssa_pkg::StZero;
            state_next  = ssa_pkg::S_DONE;
          end else begin
            state_next = ssa_pkg::S_GET;
          end
        end else if (stat.free_bad || stat.sc_zero) begin
          ctrl.cmd    = ssa_pkg::CMD_STATUS;
          ctrl.status = ssa_pkg::StNotOwned;
          state_next  = ssa_pkg::S_DONE;
        end else begin
          ctrl.cmd   = ssa_pkg::CMD_FREE_DIV;
          state_next = ssa_pkg::S_FDIV;
        end
      end
      ssa_pkg::S_GET: begin
        if (!stat.partial_empty) begin
          ctrl.cmd   = ssa_pkg::CMD_SCAN_START;
          state_next = ssa_pkg::S_SCAN_RD;
        end else if (stat.empty_avail) begin
          ctrl.cmd = ssa_pkg::CMD_POP;
        end else if (stat.can_make) begin
          ctrl.cmd   = ssa_pkg::CMD_MAKE_START;
          state_next = ssa_pkg::S_MAKE;
        end else begin
          ctrl.cmd    = ssa_pkg::CMD_STATUS;
          ctrl.status = ssa_pkg::StNoSlab;
          state_next  = ssa_pkg::S_DONE;
        end
      end
      ssa_pkg::S_MAKE: begin
        ctrl.cmd = ssa_pkg::CMD_MAKE_WR;
        if (stat.make_last) state_next = ssa_pkg::S_GET;
      end
      ssa_pkg::S_SCAN_RD: begin
        ctrl.cmd   = ssa_pkg::CMD_READ;
        state_next = ssa_pkg::S_SCAN_CHK;
      end
      ssa_pkg::S_SCAN_CHK: begin
        if (stat.word_ones) begin
          if (stat.ptr_last) begin
            ctrl.cmd   = ssa_pkg::CMD_TO_FULL;
            state_next = ssa_pkg::S_GET;
          end else begin
            ctrl.cmd   = ssa_pkg::CMD_NEXT;
            state_next = ssa_pkg::S_SCAN_RD;
          end
        end else begin
          ctrl.cmd   = ssa_pkg::CMD_MARK;
          state_next = stat.ptr_last ? ssa_pkg::S_FULL_END : ssa_pkg::S_FULL_RD;
        end
      end
      ssa_pkg::S_FULL_RD: begin
        ctrl.cmd   = ssa_pkg::CMD_READ;
        state_next = ssa_pkg::S_FULL_CHK;
      end
      ssa_pkg::S_FULL_CHK: begin
        ctrl.cmd   = ssa_pkg::CMD_FULL_NEXT;
        state_next = stat.ptr_last ? ssa_pkg::S_FULL_END : ssa_pkg::S_FULL_RD;
      end
      ssa_pkg::S_FULL_END: begin
        if (stat.full) ctrl.cmd = ssa_pkg::CMD_TO_FULL;
        state_next = ssa_pkg::S_ADDR;
      end
      ssa_pkg::S_ADDR: begin
        ctrl.cmd   = ssa_pkg::CMD_ADDR;
        state_next = ssa_pkg::S_DONE;
      end
      ssa_pkg::S_FDIV: begin
        if (stat.div_done) begin
          ctrl.cmd   = ssa_pkg::CMD_IDX;
          state_next = ssa_pkg::S_FCHK;
        end
      end
      ssa_pkg::S_FCHK: begin
        if (stat.idx_bad) begin
          ctrl.cmd    = ssa_pkg::CMD_STATUS;
          ctrl.status = ssa_pkg::StNotOwned;
          state_next  = ssa_pkg::S_DONE;
        end else begin
          ctrl.cmd   = ssa_pkg::CMD_FREE_RD;
          state_next = ssa_pkg::S_FWR;
        end
      end
      ssa_pkg::S_FWR: begin
        ctrl.cmd   = ssa_pkg::CMD_FREE_WR;
        state_next = ssa_pkg::S_ERD;
      end
      ssa_pkg::S_ERD: begin
        ctrl.cmd   = ssa_pkg::CMD_READ;
        state_next = ssa_pkg::S_ECHK;
      end
      ssa_pkg::S_ECHK: begin
        ctrl.cmd   = ssa_pkg::CMD_EMPTY_NEXT;
        state_next = stat.ptr_last ? ssa_pkg::S_FPUSH : ssa_pkg::S_ERD;
      end
      ssa_pkg::S_FPUSH: begin
        ctrl.cmd   = ssa_pkg::CMD_PUSH_FREE;
        state_next = ssa_pkg::S_DONE;
      end
      ssa_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          ctrl.out_load = 1'b1;
          state_next    = ssa_pkg::S_IDLE;
        end
      end
      default: state_next = ssa_pkg::S_IDLE;
    endcase
  end

  // a new request is only taken while idle
  a_stall: assert property (@(posedge clk) disable iff (rst)
    state != ssa_pkg::S_IDLE |-> in_stall)
    else $error("request taken while busy");

  // loading the output register raises valid
  a_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |=> out_valid)
    else $error("result lost on load");

  // an accepted request starts the slot count division
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ssa_pkg::S_DIV)
    else $error("request not started");

  // a pending result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !ctrl.out_load)
    else $error("pending result overwritten");

endmodule

// ===== rtl/slab_slot_allocator.sv =====
// top level of the slab slot allocator
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall   ssa_pkg::req_t
//  out      output     out_valid / out_stall ssa_pkg::rsp_t
//  cfg      input      cfg_write             cfg_index, cfg_data
//
// one request at a time; each request starts with a division for the slot count
// alloc: the scan and the full check together
// read each word of the slab once (up to 32), plus a write of all 32 words for a new slab
// free: a second division, then a read of each word for the empty check
// rst is synchronous; lists empty, no slabs made, registers at defaults
// a finished result waits in the output register while the next request runs
module slab_slot_allocator (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ssa_pkg::req_t           in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ssa_pkg::rsp_t           out_data,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [ssa_pkg::ObjW-1:0] cfg_data
);

  ssa_pkg::ctrl_t ctrl;
  ssa_pkg::stat_t stat;

  // sequencer
  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // datapath
  ssa_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ===== dv/slab_slot_allocator_tb.sv =====
// self-checking testbench for the slab slot allocator with its own slot and list predictor
module slab_slot_allocator_tb;

  localparam logic ReqFree  = 1'b1;
  localparam int   PageB    = 4096;
  localparam int   SlotCap  = ssa_pkg::SlabWords * ssa_pkg::WordBits;
  localparam int   IdleLim  = 20000;
  localparam int   SettleCy = 300;

  // predictor of the allocator plus the queue of awaited responses
  class alloc_scoreboard;
    logic [ssa_pkg::WordBits-1:0] bmap [ssa_pkg::MaxSlabs][ssa_pkg::SlabWords];
    int unsigned link [ssa_pkg::MaxSlabs];
    logic [1:0]  cls [ssa_pkg::MaxSlabs];
    int unsigned part_hd, empty_hd, full_hd, made;
    int unsigned obj_b, order;
    ssa_pkg::rsp_t awaited[$];
    logic [ssa_pkg::AddrW-1:0] live[$];
    int          errors;

    function new();
      obj_b = 8; order = 0;
      part_hd = ssa_pkg::MaxSlabs; empty_hd = ssa_pkg::MaxSlabs;
      full_hd = ssa_pkg::MaxSlabs; made = 0;
      errors = 0;
      for (int s = 0; s < ssa_pkg::MaxSlabs; s++) begin
        link[s] = 0; cls[s] = ssa_pkg::ClsUnused;
        for (int w = 0; w < ssa_pkg::SlabWords; w++) bmap[s][w] = '0;
      end
    endfunction

    function int unsigned rounded();
      return (obj_b + 7) & ~32'd7;
    endfunction

    function int unsigned slab_sz();
      return PageB << ((order > ssa_pkg::MaxOrder) ? ssa_pkg::MaxOrder : order);
    endfunction

    function int unsigned slots();
      int unsigned n;
      if (rounded() == 0) return 0;
      n = slab_sz() / rounded();
      return (n > SlotCap) ? SlotCap : n;
    endfunction

    function void push_to(ref int unsigned hd, input int unsigned s, input logic [1:0] c);
      link[s] = hd; cls[s] = c; hd = s;
    endfunction

    function void unlink(ref int unsigned hd, input int unsigned s);
      int unsigned cur, prev;
      cur = hd; prev = ssa_pkg::MaxSlabs;
      for (int n = 0; n < ssa_pkg::MaxSlabs && cur < ssa_pkg::MaxSlabs; n++) begin
        if (cur == s) begin
          if (prev == ssa_pkg::MaxSlabs) hd = link[cur];
          else link[prev] = link[cur];
          return;
        end
        prev = cur; cur = link[cur];
      end
    endfunction

    function ssa_pkg::rsp_t alloc(int unsigned sc);
      ssa_pkg::rsp_t r;
      int unsigned nw, s, w, b;
      bit full;
      r = '0;
      nw = (sc + 63) >> 6;
      for (int it = 0; it < 2 * ssa_pkg::MaxSlabs + 2; it++) begin
        // refill the partial list when it runs dry
        if (part_hd >= ssa_pkg::MaxSlabs) begin
          if (empty_hd < ssa_pkg::MaxSlabs) begin
            s = empty_hd; empty_hd = link[s];
          end else if (made < ssa_pkg::MaxSlabs) begin
            s = made++;
            for (int i = 0; i < SlotCap; i++) bmap[s][i >> 6][i & 63] = (i >= sc);
          end else begin
            r.status = ssa_pkg::StNoSlab;
            return r;
          end
          push_to(part_hd, s, ssa_pkg::ClsPartial);
        end
        s = part_hd;
        for (w = 0; w < nw && bmap[s][w] == ssa_pkg::AllOnes; w++) ;
        // a full head left behind by a size change
        if (w == nw) begin
          part_hd = link[s];
          push_to(full_hd, s, ssa_pkg::ClsFull);
          continue;
        end
        for (b = 0; b < 63 && bmap[s][w][b]; b++) ;
        bmap[s][w][b] = 1'b1;
        full = 1;
        for (int i = 0; i < nw; i++) if (bmap[s][i] != ssa_pkg::AllOnes) full = 0;
        if (full) begin
          part_hd = link[s];
          push_to(full_hd, s, ssa_pkg::ClsFull);
        end
        r.object_address = ssa_pkg::AddrW'(s * slab_sz() + (w * 64 + b) * rounded());
        r.status = ssa_pkg::StOk;
        live.push_back(r.object_address);
        return r;
      end
      r.status = ssa_pkg::StNoSlab;
      return r;
    endfunction

    function ssa_pkg::rsp_t release_slot(int unsigned addr);
      ssa_pkg::rsp_t r;
      int unsigned sb, s, sc, idx, whole;
      bit empty;
      r = '0;
      r.status = ssa_pkg::StNotOwned;
      sb = slab_sz(); sc = slots();
      s = addr / sb;
      if (s >= made) return r;
      if (cls[s] != ssa_pkg::ClsPartial && cls[s] != ssa_pkg::ClsFull) return r;
      if (sc == 0) return r;
      idx = (addr - s * sb) / rounded();
      if (idx >= sc) return r;
      bmap[s][idx >> 6][idx & 63] = 1'b0;
      if (cls[s] == ssa_pkg::ClsFull) unlink(full_hd, s);
      else unlink(part_hd, s);
      // empty check covers valid slots only
      empty = 1; whole = sc >> 6;
      for (int i = 0; i < whole; i++) if (bmap[s][i] != '0) empty = 0;
      if ((sc & 63) != 0 && (bmap[s][whole] & ((64'd1 << (sc & 63)) - 1)) != '0) empty = 0;
      if (empty) push_to(empty_hd, s, ssa_pkg::ClsEmpty);
      else push_to(part_hd, s, ssa_pkg::ClsPartial);
      r.status = ssa_pkg::StOk;
      return r;
    endfunction

    function void note_request(ssa_pkg::req_t q);
      ssa_pkg::rsp_t r;
      if (q.req_type == ssa_pkg::ReqAlloc) begin
        if (slots() == 0) begin
          r = '0; r.status = ssa_pkg::StZero;
        end else r = alloc(slots());
      end else r = release_slot(q.free_address);
      awaited.push_back(r);
    endfunction

    function void check_response(ssa_pkg::rsp_t got);
      ssa_pkg::rsp_t exp;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response addr=%0d status=%0d",
                                   got.object_address, got.status);
        return;
      end
      exp = awaited.pop_front();
      if (got.object_address !== exp.object_address || got.status !== exp.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                   exp.object_address, exp.status, got.object_address, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ssa_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ssa_pkg::rsp_t out_data;
  logic cfg_write = 1'b0;
  logic cfg_index = ssa_pkg::CfgObjectBytes;
  logic [ssa_pkg::ObjW-1:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int in_idle = 29, out_idle = 65;
  int quiet = 0;

  always #2 clk = ~clk;

  slab_slot_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // response side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_response(out_data);
    out_stall <= !rst && ($urandom_range(99) < out_idle);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IdleLim) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic send(logic kind, logic [ssa_pkg::AddrW-1:0] addr);
    ssa_pkg::req_t q;
    q.req_type = kind; q.free_address = addr;
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (in_stall);
    sb.note_request(q);
  endtask

  // sender holds off until every awaited response is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SettleCy) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned ob, int unsigned ord);
    drain();
    cfg_write <= 1'b1; cfg_index <= ssa_pkg::CfgObjectBytes;
    cfg_data <= ssa_pkg::ObjW'(ob);
    @(posedge clk);
    cfg_index <= ssa_pkg::CfgSlabOrder; cfg_data <= ssa_pkg::ObjW'(ord);
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.obj_b = ob; sb.order = ord & 3;
  endtask

  // mostly allocations and frees of live slots, some noise
  task automatic random_items(int n);
    int k, pick;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 52) send(ssa_pkg::ReqAlloc, ssa_pkg::AddrW'($urandom));
      else if (k < 92 && sb.live.size() != 0) begin
        pick = $urandom_range(sb.live.size() - 1);
        send(ReqFree, sb.live[pick]);
        sb.live.delete(pick);
      end else send(ReqFree, ssa_pkg::AddrW'($urandom));
      if (i == n / 2 && $urandom_range(3) == 0) drain();
    end
  endtask

  int unsigned cfg_ob [8]  = '{8, 1, 16384, 24, 4096, 32767, 100, 2000};
  int unsigned cfg_ord [8] = '{0, 2, 2, 1, 0, 3, 0, 1};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, double free, foreign and unmade slab addresses
    send(ReqFree, 17'd0);
    repeat (3) send(ssa_pkg::ReqAlloc, 17'd0);
    send(ReqFree, 17'd0);
    send(ReqFree, 17'd0);
    send(ReqFree, 17'h1FFFF);
    send(ReqFree, 17'd4096);
    send(ssa_pkg::ReqAlloc, 17'h1FFFF);
    // zero slots by size 0 and by size above the slab
    set_regs(0, 0);
    send(ssa_pkg::ReqAlloc, 17'd0);
    send(ReqFree, 17'd8);
    set_regs(16384, 0);
    send(ssa_pkg::ReqAlloc, 17'd0);
    // tail slot free and full head after a size change
    set_regs(24, 0);
    send(ssa_pkg::ReqAlloc, 17'd0);
    send(ReqFree, 17'd4080);
    // allocations across new slabs, four slots per slab, order above the maximum
    set_regs(4096, 3);
    repeat (9) send(ssa_pkg::ReqAlloc, 17'd0);
    send(ReqFree, 17'd16384);
    sb.live.delete();

    // random phases over several register settings
    for (int p = 0; p < 9; p++) begin
      in_idle  = (p < 3) ? 29 : (p < 6) ? 65 : 0;
      out_idle = (p < 3) ? 65 : (p < 6) ? 29 : 0;
      set_regs(cfg_ob[p % 8], cfg_ord[p % 8]);
      random_items(128);
    end

    drain();
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
